// ----- src/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// Steric clash check package
// Shared sizes, status codes and record types of the placement check block.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Table depth and coordinate width.
    localparam int MAX_ATOMS  = 256;
    localparam int COORD_BITS = 16;

    localparam int ADDR_W   = $clog2(MAX_ATOMS);
    localparam int CNT_W    = $clog2(MAX_ATOMS + 1);
    localparam int SIG_W    = 16;
    localparam int RAD_W    = 15;
    localparam int R2_W     = 2 * RAD_W;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int MAG_W    = 17;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int D2_W     = SQ_W + 2;
    localparam int SS_W     = SIG_W + 1;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int STORED_W = 9;
    localparam int WIDE_W   = 34;

    localparam logic [RAD_W-1:0]  RAD_RESET = RAD_W'(32767);
    // A coordinate difference at or above this can never clash.
    localparam logic [WIDE_W-1:0] FAR_LIM   = WIDE_W'(131072);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLASH   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [SIG_W-1:0]      sigma;
    } atom_t;

    // One slot of the scan: either the sphere test or one stored atom.
    typedef struct packed {
        logic              valid;
        logic              sphere;
        logic              last;
        logic [ADDR_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic              valid;
        logic              sphere;
        logic              last;
        logic [ADDR_W-1:0] idx;
        logic              flag;
    } result_t;

    function automatic logic [DIFF_W-1:0] abs_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m;
    endfunction

endpackage

// ----- src/scc_atom_ram.sv -----
// ----------------------------------------------------------------------------
// Atom table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scc_atom_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [scc_pkg::ADDR_W-1:0] waddr,
    input  scc_pkg::atom_t            wdata,
    input  logic                      re,
    input  logic [scc_pkg::ADDR_W-1:0] raddr,
    output scc_pkg::atom_t            rdata
);

    scc_pkg::atom_t mem [scc_pkg::MAX_ATOMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/scc_dist_pipe.sv -----
// ----------------------------------------------------------------------------
// Distance test pipeline
// Squared-distance test of the candidate against the origin or a stored atom.
// ----------------------------------------------------------------------------
module scc_dist_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scc_pkg::slot_t             issue,
    input  scc_pkg::atom_t             rd_atom,
    input  scc_pkg::atom_t             cand,
    input  logic [scc_pkg::RAD_W-1:0]  radius,
    input  logic [scc_pkg::R2_W-1:0]   radius_sq,
    output scc_pkg::result_t           result
);

    scc_pkg::slot_t tag0_reg;
    scc_pkg::slot_t taga_reg;
    scc_pkg::slot_t tagb_reg;
    scc_pkg::slot_t tagc_reg;

    scc_pkg::atom_t atom;
    logic signed [scc_pkg::DIFF_W-1:0] dx;
    logic signed [scc_pkg::DIFF_W-1:0] dy;
    logic signed [scc_pkg::DIFF_W-1:0] dz;
    logic [scc_pkg::DIFF_W-1:0] mx;
    logic [scc_pkg::DIFF_W-1:0] my;
    logic [scc_pkg::DIFF_W-1:0] mz;
    logic far_a;
    logic over_a;

    logic [scc_pkg::MAG_W-1:0] maga_reg [3];
    logic                      fara_reg;
    logic                      overa_reg;
    logic [scc_pkg::SS_W-1:0]  ssa_reg;

    logic [scc_pkg::SQ_W-1:0]  sqb_reg [3];
    logic                      farb_reg;
    logic                      overb_reg;
    logic [scc_pkg::SQ_W-1:0]  ss2b_reg;

    logic [scc_pkg::D2_W-1:0]  d2c_reg;
    logic                      farc_reg;
    logic                      overc_reg;
    logic [scc_pkg::SQ_W-1:0]  ss2c_reg;

    logic                      flag_d;
    scc_pkg::result_t          result_reg;

    // The sphere test measures the candidate against the origin.
    always_comb
    begin
        atom = tag0_reg.sphere ? '0 : rd_atom;
        dx = scc_pkg::DIFF_W'(signed'(cand.x)) - scc_pkg::DIFF_W'(signed'(atom.x));
        dy = scc_pkg::DIFF_W'(signed'(cand.y)) - scc_pkg::DIFF_W'(signed'(atom.y));
        dz = scc_pkg::DIFF_W'(signed'(cand.z)) - scc_pkg::DIFF_W'(signed'(atom.z));
        mx = scc_pkg::abs_mag(dx);
        my = scc_pkg::abs_mag(dy);
        mz = scc_pkg::abs_mag(dz);
        far_a = (scc_pkg::WIDE_W'(mx) >= scc_pkg::FAR_LIM)
             || (scc_pkg::WIDE_W'(my) >= scc_pkg::FAR_LIM)
             || (scc_pkg::WIDE_W'(mz) >= scc_pkg::FAR_LIM);
        over_a = (scc_pkg::WIDE_W'(mx) > scc_pkg::WIDE_W'(radius))
              || (scc_pkg::WIDE_W'(my) > scc_pkg::WIDE_W'(radius))
              || (scc_pkg::WIDE_W'(mz) > scc_pkg::WIDE_W'(radius));
    end

    // Outside when x^2+y^2+z^2 > r^2; clash when 4*d^2 < (si+sj)^2.
    always_comb
    begin
        if (tagc_reg.sphere)
        begin
            flag_d = overc_reg || (d2c_reg > scc_pkg::D2_W'(radius_sq));
        end
        else
        begin
            flag_d = !farc_reg
                  && ({d2c_reg, 2'b00} < (scc_pkg::D2_W + 2)'(ss2c_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg   <= '0;
            taga_reg   <= '0;
            tagb_reg   <= '0;
            tagc_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            tag0_reg <= issue;
            taga_reg <= tag0_reg;
            tagb_reg <= taga_reg;
            tagc_reg <= tagb_reg;
            result_reg.valid  <= tagc_reg.valid;
            result_reg.sphere <= tagc_reg.sphere;
            result_reg.last   <= tagc_reg.last;
            result_reg.idx    <= tagc_reg.idx;
            result_reg.flag   <= flag_d;
        end
    end

    always_ff @(posedge clk)
    begin
        maga_reg[0] <= scc_pkg::MAG_W'(mx);
        maga_reg[1] <= scc_pkg::MAG_W'(my);
        maga_reg[2] <= scc_pkg::MAG_W'(mz);
        fara_reg    <= far_a;
        overa_reg   <= over_a;
        ssa_reg     <= scc_pkg::SS_W'(cand.sigma) + scc_pkg::SS_W'(atom.sigma);

        for (int i = 0; i < 3; i++)
        begin
            sqb_reg[i] <= scc_pkg::SQ_W'(maga_reg[i]) * scc_pkg::SQ_W'(maga_reg[i]);
        end
        farb_reg  <= fara_reg;
        overb_reg <= overa_reg;
        ss2b_reg  <= scc_pkg::SQ_W'(ssa_reg) * scc_pkg::SQ_W'(ssa_reg);

        d2c_reg   <= scc_pkg::D2_W'(sqb_reg[0]) + scc_pkg::D2_W'(sqb_reg[1])
                   + scc_pkg::D2_W'(sqb_reg[2]);
        farc_reg  <= farb_reg;
        overc_reg <= overb_reg;
        ss2c_reg  <= ss2b_reg;
    end

    assign result = result_reg;

endmodule

// ----- src/steric_clash_placement_check_core.sv -----
// ----------------------------------------------------------------------------
// Steric clash placement check
// Hard-sphere insertion of candidate atoms into a table of placed atoms.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Handshake           Payload
// request      in         start, busy         req_type, pos_x, pos_y, pos_z, sigma
// result       out        done (strobe)       status, clash_index, stored_count
// radius cfg   in         cfg_we              cfg_wdata
//
// A request transfer happens at a rising edge with start high and busy low.
// A clear or a proposal into a full table needs no scan: done is high in the
// cycle after the transfer. A proposal walks the table one atom per cycle
// through the single read port of the atom memory, after one extra slot for
// the sphere test; done follows once the last slot has passed the distance
// pipeline. Busy stays high until done. The result is shown for one cycle
// only and cannot be held off by the receiver.
// Reset empties the table and sets the radius to 32767; the memory contents
// need no clearing, since only entries below the atom count are read.
//
module steric_clash_placement_check_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic signed [15:0]             pos_x,
    input  logic signed [15:0]             pos_y,
    input  logic signed [15:0]             pos_z,
    input  logic [scc_pkg::SIG_W-1:0]      sigma,
    output logic                           done,
    output logic [scc_pkg::STATUS_W-1:0]   status,
    output logic [scc_pkg::INDEX_W-1:0]    clash_index,
    output logic [scc_pkg::STORED_W-1:0]   stored_count,
    input  logic                           cfg_we,
    input  logic [scc_pkg::RAD_W-1:0]      cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    scc_pkg::atom_t                  cand_reg, cand_next;
    logic [scc_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [scc_pkg::CNT_W-1:0]       slot_reg, slot_next;
    logic                            outside_reg, outside_next;
    logic                            hit_found_reg, hit_found_next;
    logic [scc_pkg::ADDR_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                            done_reg, done_next;
    logic [scc_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [scc_pkg::INDEX_W-1:0]     index_reg, index_next;
    logic [scc_pkg::STORED_W-1:0]    stored_reg, stored_next;

    logic [scc_pkg::RAD_W-1:0]       radius_reg;
    logic [scc_pkg::R2_W-1:0]        radius_sq_reg;

    scc_pkg::slot_t                  issue;
    scc_pkg::result_t                result;
    scc_pkg::atom_t                  rd_atom;
    logic                            wr_en;

    logic                            outside_now;
    logic                            hit_new;
    logic                            hit_now;
    logic [scc_pkg::ADDR_W-1:0]      hit_idx_now;

    // Writes to the table happen only after the scan has drained, so a read
    // and a write of the same entry never overlap.
    scc_atom_ram u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[scc_pkg::ADDR_W-1:0]),
        .wdata (cand_reg),
        .re    (issue.valid && !issue.sphere),
        .raddr (issue.idx),
        .rdata (rd_atom)
    );

    scc_dist_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .rd_atom   (rd_atom),
        .cand      (cand_reg),
        .radius    (radius_reg),
        .radius_sq (radius_sq_reg),
        .result    (result)
    );

    // The squared radius follows the register in the next cycle. The register
    // must be written only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= scc_pkg::RAD_RESET;
            radius_sq_reg <= scc_pkg::R2_W'(scc_pkg::RAD_RESET)
                           * scc_pkg::R2_W'(scc_pkg::RAD_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            radius_sq_reg <= scc_pkg::R2_W'(radius_reg) * scc_pkg::R2_W'(radius_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        outside_next   = outside_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        stored_next    = stored_reg;
        issue          = '0;
        wr_en          = 1'b0;

        // Results come back in scan order, so the first flagged atom is the
        // first clash.
        outside_now = outside_reg || (result.valid && result.sphere && result.flag);
        hit_new     = result.valid && !result.sphere && result.flag && !hit_found_reg;
        hit_now     = hit_found_reg || hit_new;
        hit_idx_now = hit_new ? result.idx : hit_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cand_next.x     = scc_pkg::COORD_BITS'($unsigned(pos_x));
                    cand_next.y     = scc_pkg::COORD_BITS'($unsigned(pos_y));
                    cand_next.z     = scc_pkg::COORD_BITS'($unsigned(pos_z));
                    cand_next.sigma = sigma;
                    if (req_type)
                    begin
                        count_next  = '0;
                        done_next   = 1'b1;
                        status_next = scc_pkg::ST_OK;
                        index_next  = '0;
                        stored_next = '0;
                    end
                    else if (count_reg == scc_pkg::CNT_W'(scc_pkg::MAX_ATOMS))
                    begin
                        done_next   = 1'b1;
                        status_next = scc_pkg::ST_FULL;
                        index_next  = '0;
                        stored_next = scc_pkg::STORED_W'(count_reg);
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        slot_next      = '0;
                        outside_next   = 1'b0;
                        hit_found_next = 1'b0;
                        hit_idx_next   = '0;
                    end
                end
            end

            // Slot zero is the sphere test, slot k reads stored atom k-1.
            S_SCAN:
            begin
                issue.valid  = 1'b1;
                issue.sphere = (slot_reg == '0);
                issue.last   = (slot_reg == count_reg);
                issue.idx    = scc_pkg::ADDR_W'(slot_reg - scc_pkg::CNT_W'(1));
                if (slot_reg == count_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    slot_next = slot_reg + scc_pkg::CNT_W'(1);
                end
            end

            S_DRAIN:
            begin
                state_next = S_DRAIN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (result.valid)
        begin
            outside_next   = outside_now;
            hit_found_next = hit_now;
            hit_idx_next   = hit_idx_now;
            if (result.last)
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                index_next = '0;
                if (outside_now)
                begin
                    status_next = scc_pkg::ST_OUTSIDE;
                    stored_next = scc_pkg::STORED_W'(count_reg);
                end
                else if (hit_now)
                begin
                    status_next = scc_pkg::ST_CLASH;
                    index_next  = scc_pkg::INDEX_W'(hit_idx_now);
                    stored_next = scc_pkg::STORED_W'(count_reg);
                end
                else
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + scc_pkg::CNT_W'(1);
                    status_next = scc_pkg::ST_OK;
                    stored_next = scc_pkg::STORED_W'(count_reg + scc_pkg::CNT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cand_reg      <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            outside_reg   <= 1'b0;
            hit_found_reg <= 1'b0;
            hit_idx_reg   <= '0;
            done_reg      <= 1'b0;
            status_reg    <= scc_pkg::ST_OK;
            index_reg     <= '0;
            stored_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cand_reg      <= cand_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            outside_reg   <= outside_next;
            hit_found_reg <= hit_found_next;
            hit_idx_reg   <= hit_idx_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            index_reg     <= index_next;
            stored_reg    <= stored_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign clash_index  = index_reg;
    assign stored_count = stored_reg;

endmodule

// ----- tb/sv/steric_clash_placement_check_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Steric clash placement check testbench
// Drives clear and propose requests into the placement check core, keeps a
// shadow table of placed atoms to predict every result, and compares each
// result strobe field by field against the oldest prediction. The radius
// register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module steric_clash_placement_check_core_tb;

    import scc_pkg::*;

    // Request kinds as seen on req_type.
    localparam logic REQ_PROPOSE = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    // The slowest proposal scans 255 atoms through the pipeline, and the sender
    // may idle between items. The limit covers that worst case for every item
    // several times over.
    localparam int  SCAN_LATENCY = MAX_ATOMS + 8;
    localparam int  CYCLE_LIMIT  = 6000000;
    localparam int  MAX_REPORTS  = 60;
    localparam int  PHASE_ITEMS  = 315;
    localparam int  RECENT_DEPTH = 32;

    // One request transfer as the sender sees it. When drain_first is set the
    // sender holds the item back until every earlier result has arrived.
    typedef struct {
        logic               req_type;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [SIG_W-1:0]   sigma;
        bit                 drain_first;
    } placement_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  clash_index;
        logic [STORED_W-1:0] stored_count;
    } placement_res_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                req_type     = REQ_PROPOSE;
    logic signed [15:0]  pos_x        = '0;
    logic signed [15:0]  pos_y        = '0;
    logic signed [15:0]  pos_z        = '0;
    logic [SIG_W-1:0]    sigma        = '0;
    logic                cfg_we       = 1'b0;
    logic [RAD_W-1:0]    cfg_wdata    = '0;

    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  clash_index;
    logic [STORED_W-1:0] stored_count;

    // Shadow copy of the atom table and the radius register.
    logic signed [15:0]  placed_x     [MAX_ATOMS];
    logic signed [15:0]  placed_y     [MAX_ATOMS];
    logic signed [15:0]  placed_z     [MAX_ATOMS];
    logic [SIG_W-1:0]    placed_sigma [MAX_ATOMS];
    int                  placed_count = 0;
    logic [RAD_W-1:0]    radius_shadow = RAD_RESET;

    placement_req_t      pending_reqs[$];
    placement_res_t      predicted_outcomes[$];
    placement_req_t      recent_proposals[$];
    placement_req_t      in_flight;

    // issued_count is owned by the driver; received_count is updated with a
    // nonblocking assignment so every reader at an edge sees the same value.
    int                  issued_count   = 0;
    int                  received_count = 0;
    int                  error_count    = 0;
    int                  cycle_count    = 0;
    int                  burst_left     = 0;
    int                  gap_left       = 0;

    steric_clash_placement_check_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .sigma        (sigma),
        .done         (done),
        .status       (status),
        .clash_index  (clash_index),
        .stored_count (stored_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Predicts the result of one request and updates the shadow table. The
    // order of tests matters: a full table refuses before the sphere test,
    // and the sphere test refuses before any clash scan.
    function automatic placement_res_t predict_placement(input placement_req_t rq);
        placement_res_t res;
        longint         ax, ay, az, r;
        longint         dx, dy, dz, d2, ss;
        int             j;
        bit             hit;
        res.status      = ST_OK;
        res.clash_index = '0;
        hit             = 1'b0;
        if (rq.req_type == REQ_CLEAR)
        begin
            placed_count = 0;
        end
        else if (placed_count >= MAX_ATOMS)
        begin
            res.status = ST_FULL;
        end
        else
        begin
            ax = magnitude(longint'(rq.x));
            ay = magnitude(longint'(rq.y));
            az = magnitude(longint'(rq.z));
            r  = longint'(radius_shadow);
            // A point exactly on the sphere surface is still allowed.
            if (ax > r || ay > r || az > r || ax * ax + ay * ay + az * az > r * r)
            begin
                res.status = ST_OUTSIDE;
            end
            else
            begin
                j = 0;
                while (j < placed_count && !hit)
                begin
                    dx = magnitude(longint'(rq.x) - longint'(placed_x[j]));
                    dy = magnitude(longint'(rq.y) - longint'(placed_y[j]));
                    dz = magnitude(longint'(rq.z) - longint'(placed_z[j]));
                    d2 = dx * dx + dy * dy + dz * dz;
                    ss = longint'(rq.sigma) + longint'(placed_sigma[j]);
                    // Distance below half the sigma sum, compared squared.
                    if (4 * d2 < ss * ss)
                    begin
                        hit             = 1'b1;
                        res.status      = ST_CLASH;
                        res.clash_index = INDEX_W'(j);
                    end
                    j++;
                end
                if (!hit)
                begin
                    placed_x[placed_count]     = rq.x;
                    placed_y[placed_count]     = rq.y;
                    placed_z[placed_count]     = rq.z;
                    placed_sigma[placed_count] = rq.sigma;
                    placed_count++;
                end
            end
        end
        res.stored_count = STORED_W'(placed_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A request transfer happens at an edge where start is high and
    // busy is low. The prediction is made at that edge, so it always sees the
    // shadow state left by the previous transfer. Items go out in bursts of
    // random length separated by random gaps; an item marked drain_first is
    // held until nothing is outstanding any more.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        bit transfer;
        int outstanding;
        transfer = start && !busy;
        if (rst_n)
        begin
            if (transfer)
            begin
                predicted_outcomes.push_back(predict_placement(in_flight));
                issued_count++;
            end
            // A result strobed in the cycle that ends now has arrived.
            outstanding = issued_count - received_count - (done ? 1 : 0);
            if (!(start && !transfer))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain_first || outstanding == 0))
                begin
                    in_flight = pending_reqs.pop_front();
                    req_type  <= in_flight.req_type;
                    pos_x     <= in_flight.x;
                    pos_y     <= in_flight.y;
                    pos_z     <= in_flight.z;
                    sigma     <= in_flight.sigma;
                    start     <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // Mostly short bursts with short gaps, sometimes long
                        // gaps that outlast a whole scan, and sometimes long
                        // stretches with no idling at all.
                        if ($urandom_range(0, 5) == 0)
                        begin
                            burst_left = $urandom_range(50, 200);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(0, 300) : $urandom_range(0, 12);
                        end
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. The receiver cannot stall, so every strobe is a transfer and is
    // checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        placement_res_t want;
        if (rst_n && done)
        begin
            if (predicted_outcomes.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d index %0d count %0d",
                             $time, status, clash_index, stored_count);
                error_count++;
            end
            else
            begin
                want = predicted_outcomes.pop_front();
                received_count <= received_count + 1;
                if (status !== want.status)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, status);
                    error_count++;
                end
                if (clash_index !== want.clash_index)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: clash_index mismatch, expected %0d, actual %0d",
                                 $time, want.clash_index, clash_index);
                    error_count++;
                end
                if (stored_count !== want.stored_count)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: stored_count mismatch, expected %0d, actual %0d",
                                 $time, want.stored_count, stored_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("steric_clash_placement_check_core_tb: FAIL");
            $finish;
        end
    end

    function automatic placement_req_t make_req(input logic kind, input int x, input int y,
                                                input int z, input int s);
        placement_req_t rq;
        rq.req_type    = kind;
        rq.x           = 16'(x);
        rq.y           = 16'(y);
        rq.z           = 16'(z);
        rq.sigma       = 16'(s);
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    // Random request for the given radius. Most items are proposals inside
    // the sphere with small atoms, so the table grows deep; some are placed
    // right next to an earlier proposal to hit the clash boundary; the rest
    // are full-range noise and occasional clears.
    function automatic placement_req_t random_req(input int radius);
        placement_req_t rq;
        placement_req_t base;
        int             pick, rr, w;
        pick = $urandom_range(0, 99);
        rr   = radius * 57 / 100;
        if (pick < 2)
        begin
            rq = make_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end
        else if (pick < 12 || recent_proposals.size() == 0)
        begin
            rq = make_req(REQ_PROPOSE, $urandom, $urandom, $urandom, $urandom);
        end
        else if (pick < 40)
        begin
            base = recent_proposals[$urandom_range(0, recent_proposals.size() - 1)];
            w    = $urandom_range(0, 600);
            rq   = make_req(REQ_PROPOSE,
                            int'(base.x) + int'($urandom_range(0, 2 * w)) - w,
                            int'(base.y) + int'($urandom_range(0, 2 * w)) - w,
                            int'(base.z) + int'($urandom_range(0, 2 * w)) - w,
                            $urandom_range(0, 1023));
        end
        else
        begin
            rq = make_req(REQ_PROPOSE,
                          int'($urandom_range(0, 2 * rr)) - rr,
                          int'($urandom_range(0, 2 * rr)) - rr,
                          int'($urandom_range(0, 2 * rr)) - rr,
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 255));
        end
        rq.drain_first = ($urandom_range(0, 99) == 0);
        if (rq.req_type == REQ_PROPOSE)
        begin
            recent_proposals.push_back(rq);
            if (recent_proposals.size() > RECENT_DEPTH)
                recent_proposals.pop_front();
        end
        return rq;
    endfunction

    // Polls on the falling edge so the check never races the clocked blocks.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || issued_count != received_count)
            @(negedge clk);
    endtask

    // The radius is only rewritten while nothing is in flight, so the shadow
    // copy can follow right away.
    task automatic write_radius(input int value);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= RAD_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        radius_shadow = RAD_W'(value);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        placement_req_t rq;
        int             radius;
        int             phase;
        int             n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed checks at the widest radius.
        write_radius(32767);
        // Clear ignores whatever the other fields hold.
        pending_reqs.push_back(make_req(REQ_CLEAR, -1, -1, -1, 65535));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 0, 0, 0));
        // Every component at the radius, but the sum of squares is outside.
        pending_reqs.push_back(make_req(REQ_PROPOSE, 32767, 32767, 32767, 0));
        // One component beyond the radius is outside on its own.
        pending_reqs.push_back(make_req(REQ_PROPOSE, -32768, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 0, -32768, 65535));
        // On the surface with the largest sigma: clashes with the origin atom.
        pending_reqs.push_back(make_req(REQ_PROPOSE, 32767, 0, 0, 65535));
        // On the surface with zero sigma: allowed.
        pending_reqs.push_back(make_req(REQ_PROPOSE, 32767, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 1000, 0, 200));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 1100, 0, 200));
        // Distance exactly half the sigma sum does not clash.
        rq = make_req(REQ_PROPOSE, 0, 1200, 0, 200);
        rq.drain_first = 1'b1;
        pending_reqs.push_back(rq);
        // Clashes with two atoms; the lower index is reported.
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 1199, 0, 201));
        pending_reqs.push_back(make_req(REQ_PROPOSE, -20000, -1, -5, 65535));
        pending_reqs.push_back(make_req(REQ_PROPOSE, -20000, -20000, -20000, 65535));
        pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0));

        // Zero radius: only the origin is inside.
        write_radius(0);
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 0, -1, 0));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 0, 0, 5));
        pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0));

        // Fill the table with point atoms, then probe the full table. The
        // full check comes before the sphere test, and clear works from full.
        write_radius(32767);
        for (n = 0; n < MAX_ATOMS; n++)
            pending_reqs.push_back(make_req(REQ_PROPOSE,
                                            int'($urandom_range(0, 36000)) - 18000,
                                            int'($urandom_range(0, 36000)) - 18000,
                                            int'($urandom_range(0, 36000)) - 18000, 0));
        pending_reqs.push_back(make_req(REQ_PROPOSE, -32768, -32768, -32768, 65535));
        pending_reqs.push_back(make_req(REQ_PROPOSE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0));

        // Random phases over several radius settings.
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: radius = 32767;
                1: radius = $urandom_range(1, 32766);
                2: radius = 0;
                3: radius = $urandom_range(100, 600);
                default: radius = 32767;
            endcase
            write_radius(radius);
            recent_proposals.delete();
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_req(radius));
        end

        wait_idle();
        // Let a full scan time pass to catch any stray result strobe.
        repeat (SCAN_LATENCY) @(posedge clk);
        @(negedge clk);
        if (predicted_outcomes.size() != 0)
        begin
            $display("%0t: %0d results still expected, actual none arrived",
                     $time, predicted_outcomes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("steric_clash_placement_check_core_tb: PASS");
        else
            $display("steric_clash_placement_check_core_tb: FAIL");
        $finish;
    end

endmodule
